@@ hw/rtl/sliding_window_max_min_unit_assert.svh @@
// Assertion macros for the sliding window max/min unit checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef SLIDING_WINDOW_MAX_MIN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAX_MIN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SWMM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SWMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/swmm_pkg.sv @@
// Shared types and fixed widths for the sliding window max/min unit.
// No dependencies.
package swmm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CFG_W    = 9;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0]           win_len_t;

	// Per-cycle command broadcast to every candidate cell
	typedef struct packed {
		logic load;   // update the cell this cycle
		logic shift;  // take the entry from the right neighbor
		logic push;   // a new sample enters the row
		logic clear;  // end of sequence: empty the row
	} cell_ctl_t;

	// Result of one sample before the running minimum is folded in
	typedef struct packed {
		sample_t window_max;
		logic    window_full;
		logic    end_of_sequence;
	} res_t;

endpackage

@@ hw/rtl/swmm_sample_if.sv @@
// Sample channel: valid/ready handshake with sample and last flag.
// Depends on swmm_pkg.
interface swmm_sample_if;
	import swmm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

@@ hw/rtl/swmm_result_if.sv @@
// Result channel: valid/ready handshake with window max, full flag,
// running minimum and end of sequence. Depends on swmm_pkg.
interface swmm_result_if;
	import swmm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t window_max;
	logic    window_full;
	sample_t min_of_maxima;
	logic    end_of_sequence;

	modport source (output valid, output window_max, output window_full,
		output min_of_maxima, output end_of_sequence, input ready);
	modport sink   (input valid, input window_max, input window_full,
		input min_of_maxima, input end_of_sequence, output ready);
endinterface

@@ hw/rtl/swmm_cfg_if.sv @@
// Configuration write channel: valid/ready with the window length.
// Depends on swmm_pkg.
interface swmm_cfg_if;
	import swmm_pkg::*;

	logic     valid;
	logic     ready;
	win_len_t window_length;

	modport source (output valid, output window_length, input ready);
	modport sink   (input valid, input window_length, output ready);
endinterface

@@ hw/rtl/swmm_cell.sv @@
// One candidate cell of the monotonic deque row: holds a (value, position)
// pair and hands it to its left neighbor on a shift. Depends on swmm_pkg.
module swmm_cell #(
	parameter int POS_W = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swmm_pkg::cell_ctl_t ctl,
	input  logic                tail,
	input  logic                left_keep,
	input  logic                right_valid,
	input  swmm_pkg::sample_t   right_value,
	input  logic [POS_W-1:0]    right_pos,
	input  swmm_pkg::sample_t   new_value,
	input  logic [POS_W-1:0]    new_pos,
	output logic                valid,
	output swmm_pkg::sample_t   value,
	output logic [POS_W-1:0]    pos,
	output logic                keep
);
	import swmm_pkg::*;

	logic             valid_q;
	sample_t          value_q;
	logic [POS_W-1:0] pos_q;
	logic             src_valid;
	sample_t          src_value;
	logic [POS_W-1:0] src_pos;
	logic             take_new;

	// Select own entry or the right neighbor's on a shift
	assign src_valid = ctl.shift ? right_valid : valid_q;
	assign src_value = ctl.shift ? right_value : value_q;
	assign src_pos   = ctl.shift ? right_pos   : pos_q;

	// Keep unless a strictly larger new sample dominates; the tail gives way
	// to the new sample when the row is full
	assign keep     = ctl.push ? (src_valid && !tail && !(src_value < new_value)) : src_valid;
	assign take_new = ctl.push && !keep && left_keep;

	// Hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= keep || take_new;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (keep) begin
				value_q <= src_value;
				pos_q   <= src_pos;
			end else if (take_new) begin
				value_q <= new_value;
				pos_q   <= new_pos;
			end
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign pos   = pos_q;
endmodule

@@ hw/rtl/swmm_result.sv @@
// Result stage: one staging register, running minimum fold and the output
// register that drives the result channel. Depends on swmm_pkg, swmm_result_if.
module swmm_result (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  swmm_pkg::res_t   res,
	output logic             free,
	swmm_result_if.source    results
);
	import swmm_pkg::*;

	logic    s1_valid_s1;
	res_t    res_s1;
	logic    adv;
	sample_t run_min_q;
	logic    min_valid_q;
	sample_t new_min;
	logic    out_valid_q;
	sample_t out_max_q;
	logic    out_full_q;
	sample_t out_min_q;
	logic    out_eos_q;

	assign adv     = s1_valid_s1 && (!out_valid_q || results.ready);
	assign free    = !s1_valid_s1 || adv;
	assign new_min = (!min_valid_q || (res_s1.window_max < run_min_q)) ?
		res_s1.window_max : run_min_q;

	// Advance the staging register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= take || (s1_valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
	end

	// Fold full-window maxima into the running minimum, clear at end of sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q   <= '0;
			min_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			if (res_s1.end_of_sequence) begin
				run_min_q   <= '0;
				min_valid_q <= 1'b0;
			end else if (res_s1.window_full) begin
				run_min_q   <= new_min;
				min_valid_q <= 1'b1;
			end
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_max_q  <= res_s1.window_max;
			out_full_q <= res_s1.window_full;
			out_min_q  <= res_s1.window_full ? new_min : '0;
			out_eos_q  <= res_s1.end_of_sequence;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.window_max      = out_max_q;
	assign results.window_full     = out_full_q;
	assign results.min_of_maxima   = out_min_q;
	assign results.end_of_sequence = out_eos_q;
endmodule

@@ hw/rtl/sliding_window_max_min_unit.sv @@
// Sliding window maximum over a row of deque cells, with a running minimum
// of full-window maxima. Depends on swmm_pkg, the channel interfaces,
// swmm_cell and swmm_result.
//
//   channel  | dir | payload                                         | accepted when
//   ---------+-----+-------------------------------------------------+----------------
//   samples  | in  | sample, last_sample                             | valid && ready
//   results  | out | window_max, window_full, min_of_maxima, end_of_sequence | valid && ready
//   cfg      | in  | window_length                                   | valid && ready
//
// One sample per cycle unless a purge or a result stall holds it off; each result
// passes the staging register, then the output register. The deque row drops at
// most one expired front candidate per accepted sample; each further expired
// candidate (after window_length is lowered) takes a purge step in which no sample
// is taken. cfg.ready is always high. Reset empties the row at once; there is no
// clearing pass. A stalled result channel holds one result in the output register
// and one in the staging register, then drops samples.ready.
module sliding_window_max_min_unit #(
	parameter int WINDOW_MAX   = 256,
	parameter int SEQUENCE_MAX = 1048576
) (
	input  logic          clk,
	input  logic          arst_n,
	swmm_sample_if.sink   samples,
	swmm_result_if.source results,
	swmm_cfg_if.sink      cfg
);
	import swmm_pkg::*;

	localparam int POS_W = $clog2(SEQUENCE_MAX);
	localparam int CMP_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;

	win_len_t         win_len_q;
	logic [POS_W-1:0] pos_q;
	logic             full_seen_q;

	logic             c_valid [WINDOW_MAX];
	sample_t          c_value [WINDOW_MAX];
	logic [POS_W-1:0] c_pos   [WINDOW_MAX];
	logic             c_keep  [WINDOW_MAX];

	cell_ctl_t        ctl;
	logic             exp0;
	logic             exp1;
	logic             purge;
	logic             accept;
	logic             res_free;
	logic             full;
	sample_t          src0_value;
	res_t             res;
	logic [POS_W-1:0] pos_next;

	// Modular age of a candidate relative to the current position
	function automatic logic [POS_W-1:0] age_of(input logic [POS_W-1:0] cur,
		input logic [POS_W-1:0] p);
		logic [POS_W:0] diff;
		diff = {1'b0, cur} - {1'b0, p};
		if (diff[POS_W]) begin
			diff = diff + (POS_W+1)'(SEQUENCE_MAX);
		end
		return diff[POS_W-1:0];
	endfunction

	// Check the two front cells for expiry
	assign exp0 = c_valid[0] &&
		(CMP_W'(age_of(pos_q, c_pos[0])) >= CMP_W'(win_len_q));
	assign exp1 = c_valid[1] &&
		(CMP_W'(age_of(pos_q, c_pos[1])) >= CMP_W'(win_len_q));

	// Drop one extra expired candidate per cycle before taking a sample
	assign purge         = exp0 && exp1;
	assign samples.ready = res_free && !purge;
	assign accept        = samples.valid && samples.ready;

	assign ctl.load  = accept || purge;
	assign ctl.shift = purge || exp0;
	assign ctl.push  = accept;
	assign ctl.clear = accept && samples.last_sample;

	// Candidate row, front at cell 0
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cells
		swmm_cell #(.POS_W(POS_W)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.tail       (i == WINDOW_MAX - 1),
			.left_keep  ((i == 0) ? 1'b1 : c_keep[(i == 0) ? 0 : i - 1]),
			.right_valid((i == WINDOW_MAX - 1) ? 1'b0 : c_valid[(i + 1) % WINDOW_MAX]),
			.right_value(c_value[(i + 1) % WINDOW_MAX]),
			.right_pos  (c_pos[(i + 1) % WINDOW_MAX]),
			.new_value  (samples.sample),
			.new_pos    (pos_q),
			.valid      (c_valid[i]),
			.value      (c_value[i]),
			.pos        (c_pos[i]),
			.keep       (c_keep[i])
		);
	end

	// Front after this sample: kept front candidate or the sample itself
	assign src0_value = exp0 ? c_value[1] : c_value[0];
	assign full       = full_seen_q || (CMP_W'(pos_q) + CMP_W'(1) >= CMP_W'(win_len_q));

	assign res.window_max      = c_keep[0] ? src0_value : samples.sample;
	assign res.window_full     = full;
	assign res.end_of_sequence = samples.last_sample;

	assign pos_next = (pos_q == POS_W'(SEQUENCE_MAX - 1)) ? '0 : pos_q + POS_W'(1);

	swmm_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept),
		.res    (res),
		.free   (res_free),
		.results(results)
	);

	// Advance position and full flag; clear at end of sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			full_seen_q <= 1'b0;
		end else if (accept) begin
			if (samples.last_sample) begin
				pos_q       <= '0;
				full_seen_q <= 1'b0;
			end else begin
				pos_q       <= pos_next;
				full_seen_q <= full;
			end
		end
	end

	// Hold window length, clamped to 1..WINDOW_MAX
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= CFG_W'(1);
		end else if (cfg.valid) begin
			if (cfg.window_length == '0) begin
				win_len_q <= CFG_W'(1);
			end else if (32'(cfg.window_length) > WINDOW_MAX) begin
				win_len_q <= CFG_W'(WINDOW_MAX);
			end else begin
				win_len_q <= cfg.window_length;
			end
		end
	end
endmodule

@@ hw/rtl/swmm_checker.sv @@
// Port-level checks for the sliding window max/min unit, bound to the top.
// Depends on sliding_window_max_min_unit_assert.svh.
`include "sliding_window_max_min_unit_assert.svh"

module swmm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        r_valid,
	input logic        r_ready,
	input logic [31:0] r_max,
	input logic        r_full,
	input logic [31:0] r_min,
	input logic        r_eos
);
	// Stalled result keeps its payload
	`SWMM_ASSERT_NEXT(a_res_hold, r_valid && !r_ready, r_valid && $stable(r_max) && $stable(r_min) && $stable(r_full) && $stable(r_eos), "result changed while stalled")

	// Running minimum reads zero until the window fills
	`SWMM_ASSERT_NOW(a_min_zero, r_valid && !r_full, r_min == 32'd0, "min_of_maxima nonzero before window full")

	// Running minimum never exceeds the current window maximum
	`SWMM_ASSERT_NOW(a_min_le_max, r_valid && r_full, $signed(r_min) <= $signed(r_max), "min_of_maxima above window_max")

	// Running minimum never rises within a sequence
	`SWMM_ASSERT_NOW(a_min_mono, r_valid && r_full && $past(r_valid && r_ready && r_full && !r_eos) && !$past(r_valid && r_ready) == 1'b0 && $stable(r_min) == 1'b0, $signed(r_min) <= $signed($past(r_min)), "min_of_maxima rose within a sequence")
endmodule

bind sliding_window_max_min_unit swmm_checker u_swmm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.r_valid(results.valid),
	.r_ready(results.ready),
	.r_max  (results.window_max),
	.r_full (results.window_full),
	.r_min  (results.min_of_maxima),
	.r_eos  (results.end_of_sequence)
);
